### src/segi_pkg.sv
// Shared types and constants for the segment intersection block.
// Used by every module under src; depends on nothing.
package segi_pkg;

	localparam int COORD_W     = 16;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int SUM_W       = PROD_W + 1;
	localparam int MAG_W       = PROD_W;
	localparam int MARGIN_W    = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [MARGIN_W-1:0]       margin_t;

	typedef struct packed {
		coord_t a_start_x;
		coord_t a_start_y;
		coord_t a_end_x;
		coord_t a_end_y;
		coord_t b_start_x;
		coord_t b_start_y;
		coord_t b_end_x;
		coord_t b_end_y;
	} in_item_t;

	typedef struct packed {
		logic   hit;
		coord_t cross_x;
		coord_t cross_y;
	} out_item_t;

	// Classified pair handed from the front part to the back part.
	typedef struct packed {
		logic   det_zero;
		logic   s_neg;
		logic   t_neg;
		mag_t   det_mag;
		mag_t   s_mag;
		mag_t   t_mag;
		diff_t  d1x;
		diff_t  d1y;
		coord_t ax0;
		coord_t ay0;
	} work_t;

	// Full and empty flags of the queue between the two parts.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

### src/segi_front.sv
// Front part: differences, cross products, determinant and classification.
// Depends on segi_pkg.
module segi_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               load,
	input  segi_pkg::in_item_t segs,
	output logic               valid,
	output segi_pkg::work_t    work
);

	logic             v_s1, v_s2, v_s3, v_s4;
	segi_pkg::diff_t  d1x_s1, d1y_s1, d2x_s1, d2y_s1, wx_s1, wy_s1;
	segi_pkg::coord_t ax0_s1, ay0_s1;
	segi_pkg::prod_t  p_det_a_s2, p_det_b_s2, p_s_a_s2, p_s_b_s2, p_t_a_s2, p_t_b_s2;
	segi_pkg::diff_t  d1x_s2, d1y_s2;
	segi_pkg::coord_t ax0_s2, ay0_s2;
	segi_pkg::sum_t   det_s3, snum_s3, tnum_s3;
	segi_pkg::diff_t  d1x_s3, d1y_s3;
	segi_pkg::coord_t ax0_s3, ay0_s3;
	segi_pkg::work_t  work_s4;
	segi_pkg::sum_t   det_abs, snum_abs, tnum_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= load;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1x_s1 <= segi_pkg::diff_t'(segs.a_end_x) - segi_pkg::diff_t'(segs.a_start_x);
			d1y_s1 <= segi_pkg::diff_t'(segs.a_end_y) - segi_pkg::diff_t'(segs.a_start_y);
			d2x_s1 <= segi_pkg::diff_t'(segs.b_end_x) - segi_pkg::diff_t'(segs.b_start_x);
			d2y_s1 <= segi_pkg::diff_t'(segs.b_end_y) - segi_pkg::diff_t'(segs.b_start_y);
			wx_s1  <= segi_pkg::diff_t'(segs.a_start_x) - segi_pkg::diff_t'(segs.b_start_x);
			wy_s1  <= segi_pkg::diff_t'(segs.a_start_y) - segi_pkg::diff_t'(segs.b_start_y);
			ax0_s1 <= segs.a_start_x;
			ay0_s1 <= segs.a_start_y;

			p_det_a_s2 <= d1x_s1 * d2y_s1;
			p_det_b_s2 <= d2x_s1 * d1y_s1;
			p_s_a_s2   <= d1x_s1 * wy_s1;
			p_s_b_s2   <= d1y_s1 * wx_s1;
			p_t_a_s2   <= d2x_s1 * wy_s1;
			p_t_b_s2   <= d2y_s1 * wx_s1;
			d1x_s2     <= d1x_s1;
			d1y_s2     <= d1y_s1;
			ax0_s2     <= ax0_s1;
			ay0_s2     <= ay0_s1;

			det_s3  <= segi_pkg::sum_t'(p_det_a_s2) - segi_pkg::sum_t'(p_det_b_s2);
			snum_s3 <= segi_pkg::sum_t'(p_s_a_s2) - segi_pkg::sum_t'(p_s_b_s2);
			tnum_s3 <= segi_pkg::sum_t'(p_t_a_s2) - segi_pkg::sum_t'(p_t_b_s2);
			d1x_s3  <= d1x_s2;
			d1y_s3  <= d1y_s2;
			ax0_s3  <= ax0_s2;
			ay0_s3  <= ay0_s2;

			work_s4.det_zero <= (det_s3 == '0);
			work_s4.s_neg    <= snum_s3[segi_pkg::SUM_W-1] ^ det_s3[segi_pkg::SUM_W-1];
			work_s4.t_neg    <= tnum_s3[segi_pkg::SUM_W-1] ^ det_s3[segi_pkg::SUM_W-1];
			work_s4.det_mag  <= det_abs[segi_pkg::MAG_W-1:0];
			work_s4.s_mag    <= snum_abs[segi_pkg::MAG_W-1:0];
			work_s4.t_mag    <= tnum_abs[segi_pkg::MAG_W-1:0];
			work_s4.d1x      <= d1x_s3;
			work_s4.d1y      <= d1y_s3;
			work_s4.ax0      <= ax0_s3;
			work_s4.ay0      <= ay0_s3;
		end
	end

	always_comb begin
		det_abs  = det_s3[segi_pkg::SUM_W-1] ? -det_s3 : det_s3;
		snum_abs = snum_s3[segi_pkg::SUM_W-1] ? -snum_s3 : snum_s3;
		tnum_abs = tnum_s3[segi_pkg::SUM_W-1] ? -tnum_s3 : tnum_s3;
	end

	assign valid = v_s4;
	assign work  = work_s4;

endmodule

### src/segi_queue.sv
// Short queue that decouples the front part from the back part.
// Depends on segi_pkg.
module segi_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  segi_pkg::work_t       wdata,
	input  logic                  pop,
	output segi_pkg::work_t       rdata,
	output segi_pkg::queue_stat_t stat
);

	segi_pkg::work_t                  mem_q [segi_pkg::QUEUE_DEPTH];
	segi_pkg::work_t                  rdata_q;
	logic [segi_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [segi_pkg::QPTR_W:0]        count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// The head word is registered on pop and is valid in the following cycle.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
		if (pop)
			rdata_q <= mem_q[rd_ptr_q];
	end

	assign rdata      = rdata_q;
	assign stat.full  = (count_q == (segi_pkg::QPTR_W+1)'(segi_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

### src/segi_back.sv
// Back part: pipelined long division for s and t, window test and point.
// Depends on segi_pkg.
module segi_back #(
	parameter int FRAC = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  segi_pkg::work_t     work,
	input  logic [FRAC-1:0]     lo_b,
	input  logic [FRAC:0]       hi_b,
	output logic                done,
	output segi_pkg::out_item_t result
);

	localparam int QW   = FRAC + 1;
	localparam int RW   = segi_pkg::MAG_W + 1;
	localparam int PX_W = QW + 1 + segi_pkg::DIFF_W;

	logic                    v_b0;
	segi_pkg::work_t         w_b0;

	logic                    v_d     [FRAC+1];
	logic                    dz_d    [FRAC+1];
	logic                    sneg_d  [FRAC+1];
	logic                    tneg_d  [FRAC+1];
	logic                    sovf_d  [FRAC+1];
	logic                    tovf_d  [FRAC+1];
	segi_pkg::mag_t          det_d   [FRAC+1];
	segi_pkg::mag_t          srem_d  [FRAC+1];
	segi_pkg::mag_t          trem_d  [FRAC+1];
	logic [QW-1:0]           sq_d    [FRAC+1];
	logic [QW-1:0]           tq_d    [FRAC+1];
	segi_pkg::diff_t         d1x_d   [FRAC+1];
	segi_pkg::diff_t         d1y_d   [FRAC+1];
	segi_pkg::coord_t        ax0_d   [FRAC+1];
	segi_pkg::coord_t        ay0_d   [FRAC+1];

	logic                    v_m, hit_m;
	logic signed [PX_W-1:0]  px_m, py_m;
	segi_pkg::coord_t        ax0_m, ay0_m;

	logic                    done_q;
	segi_pkg::out_item_t     result_q;

	logic                    s_int, t_int, s_ok, t_ok;
	logic [RW-1:0]           s_r2_n [FRAC+1];
	logic [RW-1:0]           t_r2_n [FRAC+1];
	logic                    s_bit  [FRAC+1];
	logic                    t_bit  [FRAC+1];
	logic signed [PX_W-1:0]  rnd, px_adj, py_adj, cx, cy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b0   <= 1'b0;
			v_m    <= 1'b0;
			done_q <= 1'b0;
			for (int k = 0; k <= FRAC; k++)
				v_d[k] <= 1'b0;
		end else begin
			v_b0   <= in_valid;
			v_d[0] <= v_b0;
			for (int k = 1; k <= FRAC; k++)
				v_d[k] <= v_d[k-1];
			v_m    <= v_d[FRAC];
			done_q <= v_m;
		end
	end

	// Integer quotient bit; a numerator of twice the divisor or more is out of range anyway.
	always_comb begin
		s_int = (w_b0.s_mag >= w_b0.det_mag);
		t_int = (w_b0.t_mag >= w_b0.det_mag);
		for (int k = 1; k <= FRAC; k++) begin
			s_r2_n[k] = {srem_d[k-1], 1'b0};
			t_r2_n[k] = {trem_d[k-1], 1'b0};
			s_bit[k]  = (s_r2_n[k] >= {1'b0, det_d[k-1]});
			t_bit[k]  = (t_r2_n[k] >= {1'b0, det_d[k-1]});
		end
		s_r2_n[0] = '0;
		t_r2_n[0] = '0;
		s_bit[0]  = 1'b0;
		t_bit[0]  = 1'b0;
	end

	always_ff @(posedge clk) begin
		dz_d[0]   <= w_b0.det_zero;
		sneg_d[0] <= w_b0.s_neg;
		tneg_d[0] <= w_b0.t_neg;
		sovf_d[0] <= ({1'b0, w_b0.s_mag} >= {w_b0.det_mag, 1'b0});
		tovf_d[0] <= ({1'b0, w_b0.t_mag} >= {w_b0.det_mag, 1'b0});
		det_d[0]  <= w_b0.det_mag;
		srem_d[0] <= s_int ? w_b0.s_mag - w_b0.det_mag : w_b0.s_mag;
		trem_d[0] <= t_int ? w_b0.t_mag - w_b0.det_mag : w_b0.t_mag;
		sq_d[0]   <= QW'(s_int);
		tq_d[0]   <= QW'(t_int);
		d1x_d[0]  <= w_b0.d1x;
		d1y_d[0]  <= w_b0.d1y;
		ax0_d[0]  <= w_b0.ax0;
		ay0_d[0]  <= w_b0.ay0;

		for (int k = 1; k <= FRAC; k++) begin
			dz_d[k]   <= dz_d[k-1];
			sneg_d[k] <= sneg_d[k-1];
			tneg_d[k] <= tneg_d[k-1];
			sovf_d[k] <= sovf_d[k-1];
			tovf_d[k] <= tovf_d[k-1];
			det_d[k]  <= det_d[k-1];
			srem_d[k] <= segi_pkg::MAG_W'(s_bit[k] ? s_r2_n[k] - {1'b0, det_d[k-1]} : s_r2_n[k]);
			trem_d[k] <= segi_pkg::MAG_W'(t_bit[k] ? t_r2_n[k] - {1'b0, det_d[k-1]} : t_r2_n[k]);
			sq_d[k]   <= {sq_d[k-1][QW-2:0], s_bit[k]};
			tq_d[k]   <= {tq_d[k-1][QW-2:0], t_bit[k]};
			d1x_d[k]  <= d1x_d[k-1];
			d1y_d[k]  <= d1y_d[k-1];
			ax0_d[k]  <= ax0_d[k-1];
			ay0_d[k]  <= ay0_d[k-1];
		end

		hit_m <= !dz_d[FRAC] && s_ok && t_ok;
		px_m  <= $signed({1'b0, tq_d[FRAC]}) * d1x_d[FRAC];
		py_m  <= $signed({1'b0, tq_d[FRAC]}) * d1y_d[FRAC];
		ax0_m <= ax0_d[FRAC];
		ay0_m <= ay0_d[FRAC];

		result_q.hit     <= hit_m;
		result_q.cross_x <= hit_m ? cx[segi_pkg::COORD_W-1:0] : '0;
		result_q.cross_y <= hit_m ? cy[segi_pkg::COORD_W-1:0] : '0;
	end

	// A negative quotient only passes when it truncates to zero.
	always_comb begin
		s_ok = !sovf_d[FRAC] && (!sneg_d[FRAC] || sq_d[FRAC] == '0) &&
			(sq_d[FRAC] >= {1'b0, lo_b}) && (sq_d[FRAC] <= hi_b);
		t_ok = !tovf_d[FRAC] && (!tneg_d[FRAC] || tq_d[FRAC] == '0) &&
			(tq_d[FRAC] >= {1'b0, lo_b}) && (tq_d[FRAC] <= hi_b);
	end

	// Shift toward zero: bias negative products before the arithmetic shift.
	always_comb begin
		rnd    = $signed({{(PX_W-FRAC){1'b0}}, {FRAC{1'b1}}});
		px_adj = px_m[PX_W-1] ? px_m + rnd : px_m;
		py_adj = py_m[PX_W-1] ? py_m + rnd : py_m;
		cx     = (px_adj >>> FRAC) + PX_W'(ax0_m);
		cy     = (py_adj >>> FRAC) + PX_W'(ay0_m);
	end

	// The queue registers its head word, so it lines up with v_b0.
	assign w_b0   = work;
	assign done   = done_q;
	assign result = result_q;

endmodule

### src/segment_intersection.sv
// Segment intersection: one word accepted per cycle while busy is low.
// The path runs through the front pipeline (4), the queue and its read register,
// the long divider with one quotient bit per stage (PARAM_FRAC_BITS + 1) and two output stages.
// Throughput is one word per cycle; the back part never stalls, so busy stays low in use.
// arst_n clears all valid bits and margin_q; data registers are not reset.
module segment_intersection #(
	parameter int PARAM_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  segi_pkg::in_item_t  segs,
	input  logic                cfg_we,
	input  segi_pkg::margin_t   cfg_wdata,
	output logic                done,
	output segi_pkg::out_item_t result
);

	localparam int LATENCY = PARAM_FRAC_BITS + 9;

	segi_pkg::margin_t                          margin_q;
	logic [segi_pkg::MARGIN_W+PARAM_FRAC_BITS-1:0] margin_ext;
	logic [PARAM_FRAC_BITS-1:0]                 lo_b;
	logic [PARAM_FRAC_BITS:0]                   hi_b;
	logic                                       front_valid, push, pop;
	segi_pkg::work_t                            front_work, head_work;
	segi_pkg::queue_stat_t                      qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			margin_q <= '0;
		else if (cfg_we)
			margin_q <= cfg_wdata;
	end

	// Margin from Q0.16 to Q0.F by truncation; the window is [lo_b, 1 - lo_b].
	always_comb begin
		margin_ext = {margin_q, {PARAM_FRAC_BITS{1'b0}}};
		lo_b       = margin_ext[segi_pkg::MARGIN_W+PARAM_FRAC_BITS-1:segi_pkg::MARGIN_W];
		hi_b       = {1'b1, {PARAM_FRAC_BITS{1'b0}}} - {1'b0, lo_b};
	end

	assign busy = qstat.full;
	assign push = front_valid && !qstat.full;
	assign pop  = !qstat.empty;

	segi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (!qstat.full),
		.load   (start && !busy),
		.segs   (segs),
		.valid  (front_valid),
		.work   (front_work)
	);

	segi_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_work),
		.pop    (pop),
		.rdata  (head_work),
		.stat   (qstat)
	);

	segi_back #(
		.FRAC (PARAM_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pop),
		.work     (head_work),
		.lo_b     (lo_b),
		.hi_b     (hi_b),
		.done     (done),
		.result   (result)
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> result.cross_x == '0 && result.cross_y == '0)
		else $error("miss result carries a nonzero point");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted word did not produce a result on time");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |=> !$past(pop))
		else $error("queue popped while empty");

endmodule

### tb/segi_scoreboard.sv
`timescale 1ns / 100ps
// Watches the word and result channels of segment_intersection, predicts each crossing
// and compares it field by field. Depends on segi_pkg for the payload types.
module segi_scoreboard (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  segi_pkg::in_item_t  segs,
	input  logic                cfg_we,
	input  segi_pkg::margin_t   cfg_wdata,
	input  logic                done,
	input  segi_pkg::out_item_t result,
	output int                  errors,
	output int                  pending
);

	localparam int FRAC = 16;

	segi_pkg::out_item_t crossings_due[$];
	segi_pkg::margin_t   margin_copy;

	function automatic longint shrink_q(longint p);
		longint mag;
		mag = (p < 0) ? -p : p;
		mag = mag >>> FRAC;
		return (p < 0) ? -mag : mag;
	endfunction

	function automatic segi_pkg::out_item_t predict_crossing(segi_pkg::in_item_t w,
			segi_pkg::margin_t m);
		segi_pkg::out_item_t r;
		longint ax0, ay0, d1x, d1y, d2x, d2y, wx, wy;
		longint det, snum, tnum, s, t, lo_b, hi_b, px, py;
		r = '0;
		ax0 = w.a_start_x;
		ay0 = w.a_start_y;
		d1x = longint'(w.a_end_x) - ax0;
		d1y = longint'(w.a_end_y) - ay0;
		d2x = longint'(w.b_end_x) - longint'(w.b_start_x);
		d2y = longint'(w.b_end_y) - longint'(w.b_start_y);
		wx = ax0 - longint'(w.b_start_x);
		wy = ay0 - longint'(w.b_start_y);
		det = d1x * d2y - d2x * d1y;
		snum = d1x * wy - d1y * wx;
		tnum = d2x * wy - d2y * wx;
		if (det == 0)
			return r;
		// Numerators stay below 2^52 after scaling, so the quotient never saturates.
		s = (snum <<< FRAC) / det;
		t = (tnum <<< FRAC) / det;
		lo_b = longint'(m);
		hi_b = (longint'(1) <<< FRAC) - lo_b;
		if (s >= lo_b && s <= hi_b && t >= lo_b && t <= hi_b) begin
			px = ax0 + shrink_q(t * d1x);
			py = ay0 + shrink_q(t * d1y);
			r.hit = 1'b1;
			r.cross_x = px[segi_pkg::COORD_W-1:0];
			r.cross_y = py[segi_pkg::COORD_W-1:0];
		end
		return r;
	endfunction

	assign pending = crossings_due.size();

	always @(posedge clk or negedge arst_n) begin
		segi_pkg::out_item_t want;
		if (!arst_n) begin
			margin_copy <= '0;
			crossings_due.delete();
			errors <= 0;
		end else begin
			if (cfg_we)
				margin_copy <= cfg_wdata;
			if (start && !busy)
				crossings_due.push_back(predict_crossing(segs, margin_copy));
			if (done) begin
				if (crossings_due.size() == 0) begin
					if (errors < 10)
						$display("%0t: result word with nothing expected: %p", $realtime, result);
					errors <= errors + 1;
				end else begin
					want = crossings_due.pop_front();
					if (want.hit !== result.hit || want.cross_x !== result.cross_x ||
							want.cross_y !== result.cross_y) begin
						if (errors < 10)
							$display("%0t: mismatch exp hit=%0b x=%0d y=%0d got hit=%0b x=%0d y=%0d",
								$realtime, want.hit, want.cross_x, want.cross_y,
								result.hit, result.cross_x, result.cross_y);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

### tb/tb_segment_intersection.sv
`timescale 1ns / 100ps
// Stimulus and verdict for segment_intersection; checking lives in segi_scoreboard.
// Depends on segi_pkg, the block and segi_scoreboard.
module tb_segment_intersection;

	localparam int LATENCY = 25;
	localparam int CYCLE_LIMIT = 300000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	segi_pkg::in_item_t  segs = '0;
	logic                cfg_we = 1'b0;
	segi_pkg::margin_t   cfg_wdata = '0;
	logic                done;
	segi_pkg::out_item_t result;
	int                  errors;
	int                  pending;
	int                  cycles = 0;
	int                  burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	segment_intersection u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .segs(segs),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
	);

	segi_scoreboard u_board (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .segs(segs),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_segment_intersection: FAIL");
			$finish;
		end
	end

	// Hands one word over and returns once it is taken; start stays high inside a burst.
	task automatic send_word(segi_pkg::in_item_t w);
		int gap;
		segs <= w;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic idle_and_set(segi_pkg::margin_t m);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic segi_pkg::in_item_t make_pair(int ax, int ay, int bx, int by,
			int cx, int cy, int dx, int dy);
		segi_pkg::in_item_t w;
		w.a_start_x = segi_pkg::coord_t'(ax); w.a_start_y = segi_pkg::coord_t'(ay);
		w.a_end_x = segi_pkg::coord_t'(bx); w.a_end_y = segi_pkg::coord_t'(by);
		w.b_start_x = segi_pkg::coord_t'(cx); w.b_start_y = segi_pkg::coord_t'(cy);
		w.b_end_x = segi_pkg::coord_t'(dx); w.b_end_y = segi_pkg::coord_t'(dy);
		return w;
	endfunction

	// Half cross near a random point; others: random noise, small or parallel pairs.
	function automatic segi_pkg::in_item_t random_pair();
		segi_pkg::in_item_t w;
		int px, py, ux, uy, vx, vy, ka, kb;
		case ($urandom_range(0, 7))
			0, 1: w = {$urandom, $urandom, $urandom, $urandom};
			2: begin
				w = make_pair($urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32,
					$urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32,
					$urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32,
					$urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32);
			end
			3: begin
				// Parallel pair: the second segment is shifted and twice as long as the first.
				ux = $urandom_range(0, 4000) - 2000;
				uy = $urandom_range(0, 4000) - 2000;
				px = $urandom_range(0, 20000) - 10000;
				py = $urandom_range(0, 20000) - 10000;
				vx = $urandom_range(0, 400) - 200;
				vy = $urandom_range(0, 400) - 200;
				w = make_pair(px, py, px + ux, py + uy, px + vx, py + vy,
					px + vx + 2 * ux, py + vy + 2 * uy);
			end
			default: begin
				px = $urandom_range(0, 16000) - 8000;
				py = $urandom_range(0, 16000) - 8000;
				ux = $urandom_range(0, 4000) - 2000;
				uy = $urandom_range(0, 4000) - 2000;
				vx = $urandom_range(0, 4000) - 2000;
				vy = $urandom_range(0, 4000) - 2000;
				ka = $urandom_range(1, 8);
				kb = $urandom_range(1, 8);
				w = make_pair(px - ux, py - uy, px + ux * ka / 4, py + uy * ka / 4,
					px - vx * kb / 4, py - vy * kb / 4, px + vx, py + vy);
			end
		endcase
		return w;
	endfunction

	initial begin
		segi_pkg::margin_t margins[5];
		margins = '{16'd0, 16'd32768, 16'd1, 16'd6554, 16'hFFFF};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at reset margin.
		send_word('0);
		send_word(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		send_word(make_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
		send_word(make_pair(-160, 0, 160, 0, 0, -160, 0, 160));
		send_word(make_pair(0, 0, 160, 0, 0, 0, 0, 160));
		send_word(make_pair(0, 0, 160, 0, 160, 0, 160, 160));
		send_word(make_pair(0, 0, 160, 160, 0, 16, 160, 176));
		send_word(make_pair(0, 0, 160, 160, 32, 32, 320, 320));
		send_word(make_pair(0, 0, 16, 0, 16, -16, 16, 16));
		send_word(make_pair(0, 0, 16, 0, 17, -16, 17, 16));
		send_word(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
		send_word(make_pair(0, 0, 1, 0, 0, -32768, 0, 32767));
		send_word(make_pair(5, 5, 5, 5, 0, 0, 160, 160));
		send_word(make_pair(-100, 3, 200, 7, 50, -300, 51, 400));

		foreach (margins[p]) begin
			if (p != 0)
				idle_and_set(margins[p]);
			if (p == 1) begin
				// Crossing exactly at the middle of both segments sits on a half margin.
				send_word(make_pair(-160, 0, 160, 0, 0, -160, 0, 160));
				send_word(make_pair(-160, 0, 160, 0, 1, -160, 1, 160));
			end
			repeat (180) send_word(random_pair());
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("tb_segment_intersection: PASS");
		else
			$display("tb_segment_intersection: FAIL");
		$finish;
	end
endmodule
